FILE: rtl/core/debounced_single_double_click_selector_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef DEBOUNCED_SINGLE_DOUBLE_CLICK_SELECTOR_UNIT_MACROS_SVH
`define DEBOUNCED_SINGLE_DOUBLE_CLICK_SELECTOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBCLK_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBCLK_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dbclk_pkg.sv
package dbclk_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [CFG_W-1:0] WINDOW_RESET   = 16'd450;

    typedef enum logic {
        CFG_DEBOUNCE = 1'b0,
        CFG_WINDOW   = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_DOUBLE = 2'd2
    } t_mode;

endpackage

FILE: rtl/core/debounced_single_double_click_selector_unit.sv
// Button poll processor: each input transaction is one poll with a millisecond
// timestamp; the raw level is qualified after it holds for the debounce time,
// presses select mode one (single click, after the double-click window) or mode
// two (second click), and a press while a mode runs raises an exit request.
// One transaction is accepted per clock cycle while the output side takes
// results; a stalled output holds new polls once the input register is full.
// The poll lands in an input register, the state update is a single pass of
// compare logic into the result register, and the result register lets the
// next poll enter while a result is still waiting on the output side.
// Configuration writes take effect at the next clock edge.
module debounced_single_double_click_selector_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dbclk_pkg::TIME_W-1:0]  i_time_now,
    input  logic                          i_raw_pressed,
    input  logic                          i_mode_active,
    input  logic                          i_consume_exit,
    input  logic                          i_clear_selection,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_exit_taken,
    output logic                          o_exit_pending,
    output logic                          o_has_selection,
    output logic [1:0]                    o_chosen_mode,
    output logic                          o_debounced_level,
    output logic                          o_clicks_waiting,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [dbclk_pkg::CFG_W-1:0]   i_cfg_wdata
);

    logic [dbclk_pkg::CFG_W-1:0]  r_debounce;
    logic [dbclk_pkg::CFG_W-1:0]  r_window;

    logic                         r_in_vld;
    logic [dbclk_pkg::TIME_W-1:0] r_in_time;
    logic                         r_in_raw;
    logic                         r_in_active;
    logic                         r_in_consume;
    logic                         r_in_clear;

    logic                         r_last_raw;
    logic                         r_stable;
    logic [dbclk_pkg::TIME_W-1:0] r_change_time;
    logic [dbclk_pkg::TIME_W-1:0] r_click_time;
    logic                         r_pending;
    logic                         r_selected;
    dbclk_pkg::t_mode             r_code;
    logic                         r_exit;

    logic                         n_last_raw;
    logic                         n_stable;
    logic [dbclk_pkg::TIME_W-1:0] n_change_time;
    logic [dbclk_pkg::TIME_W-1:0] n_click_time;
    logic                         n_pending;
    logic                         n_selected;
    dbclk_pkg::t_mode             n_code;
    logic                         n_exit;
    logic                         n_taken;

    logic                         r_out_vld;
    logic                         r_out_taken;
    logic                         r_out_exit;
    logic                         r_out_selected;
    dbclk_pkg::t_mode             r_out_code;
    logic                         r_out_stable;
    logic                         r_out_pending;

    logic                         advance;
    logic                         press;
    logic [dbclk_pkg::TIME_W-1:0] held_time;
    logic [dbclk_pkg::TIME_W-1:0] wait_time;

    assign advance = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= dbclk_pkg::DEBOUNCE_RESET;
            r_window   <= dbclk_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (dbclk_pkg::t_cfg_index'(i_cfg_index))
                dbclk_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_wdata;
                dbclk_pkg::CFG_WINDOW:   r_window   <= i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_time    <= i_time_now;
            r_in_raw     <= i_raw_pressed;
            r_in_active  <= i_mode_active;
            r_in_consume <= i_consume_exit;
            r_in_clear   <= i_clear_selection;
        end
    end

    always_comb begin
        n_taken       = r_in_consume & r_exit;
        n_exit        = r_in_consume ? 1'b0 : r_exit;
        n_selected    = r_selected;
        n_code        = r_code;
        n_pending     = r_pending;
        n_click_time  = r_click_time;
        n_stable      = r_stable;
        press         = 1'b0;
        if (r_in_clear) begin
            n_selected = 1'b0;
            n_code     = dbclk_pkg::MODE_NONE;
            n_pending  = 1'b0;
        end

        n_last_raw    = r_in_raw;
        n_change_time = (r_in_raw != r_last_raw) ? r_in_time : r_change_time;
        held_time     = r_in_time - n_change_time;
        if (held_time >= dbclk_pkg::TIME_W'(r_debounce) && r_in_raw != r_stable) begin
            n_stable = r_in_raw;
            press    = r_in_raw;
        end

        if (r_in_active) begin
            if (press) begin
                n_exit     = 1'b1;
                n_pending  = 1'b0;
                n_code     = dbclk_pkg::MODE_NONE;
                n_selected = 1'b0;
            end
        end else if (!n_selected) begin
            if (press) begin
                if (!n_pending) begin
                    n_click_time = r_in_time;
                    n_pending    = 1'b1;
                end else begin
                    n_code     = dbclk_pkg::MODE_DOUBLE;
                    n_selected = 1'b1;
                    n_pending  = 1'b0;
                end
            end
        end
        wait_time = r_in_time - n_click_time;
        if (!r_in_active && !n_selected && n_pending
                && wait_time >= dbclk_pkg::TIME_W'(r_window)) begin
            n_code     = dbclk_pkg::MODE_SINGLE;
            n_selected = 1'b1;
            n_pending  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= 1'b0;
            r_stable      <= 1'b0;
            r_change_time <= '0;
            r_click_time  <= '0;
            r_pending     <= 1'b0;
            r_selected    <= 1'b0;
            r_code        <= dbclk_pkg::MODE_NONE;
            r_exit        <= 1'b0;
        end else if (advance) begin
            r_last_raw    <= n_last_raw;
            r_stable      <= n_stable;
            r_change_time <= n_change_time;
            r_click_time  <= n_click_time;
            r_pending     <= n_pending;
            r_selected    <= n_selected;
            r_code        <= n_code;
            r_exit        <= n_exit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_taken    <= n_taken;
            r_out_exit     <= n_exit;
            r_out_selected <= n_selected;
            r_out_code     <= n_code;
            r_out_stable   <= n_stable;
            r_out_pending  <= n_pending;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_exit_taken      = r_out_taken;
    assign o_exit_pending    = r_out_exit;
    assign o_has_selection   = r_out_selected;
    assign o_chosen_mode     = r_out_code;
    assign o_debounced_level = r_out_stable;
    assign o_clicks_waiting  = r_out_pending;

endmodule

FILE: rtl/core/dbclk_checker.sv
`include "debounced_single_double_click_selector_unit_macros.svh"

module dbclk_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_has_selection,
    input logic [1:0] o_chosen_mode,
    input logic       o_clicks_waiting
);

    `DBCLK_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result transaction dropped while stalled")
    `DBCLK_ASSERT_SAME(a_sel_code, i_clk, i_rst_n, o_valid, o_has_selection == (o_chosen_mode != dbclk_pkg::MODE_NONE), "selection flag and mode disagree")
    `DBCLK_ASSERT_SAME(a_sel_no_click, i_clk, i_rst_n, o_valid, !(o_has_selection && o_clicks_waiting), "click pending while a selection exists")
    `DBCLK_ASSERT_SAME(a_reset_idle, i_clk, i_rst_n, $rose(i_rst_n), !o_valid, "result valid right after reset")

endmodule

bind debounced_single_double_click_selector_unit dbclk_checker u_dbclk_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_has_selection  (o_has_selection),
    .o_chosen_mode    (o_chosen_mode),
    .o_clicks_waiting (o_clicks_waiting)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int QUIET_LIMIT = 5000;
    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        logic             exit_taken;
        logic             exit_pending;
        logic             has_sel;
        dbclk_pkg::t_mode mode;
        logic             level;
        logic             clicks;
    } t_sel_result;

    logic                         i_clk;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [dbclk_pkg::TIME_W-1:0] i_time_now = '0;
    logic                         i_raw_pressed = 1'b0;
    logic                         i_mode_active = 1'b0;
    logic                         i_consume_exit = 1'b0;
    logic                         i_clear_selection = 1'b0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic                         o_exit_taken;
    logic                         o_exit_pending;
    logic                         o_has_selection;
    logic [1:0]                   o_chosen_mode;
    logic                         o_debounced_level;
    logic                         o_clicks_waiting;
    logic                         i_cfg_we = 1'b0;
    dbclk_pkg::t_cfg_index        i_cfg_index = dbclk_pkg::CFG_DEBOUNCE;
    logic [dbclk_pkg::CFG_W-1:0]  i_cfg_wdata = '0;

    // Mirror of the selector state and timing registers.
    logic [dbclk_pkg::CFG_W-1:0]  debounce_ms_reg = dbclk_pkg::DEBOUNCE_RESET;
    logic [dbclk_pkg::CFG_W-1:0]  window_ms_reg = dbclk_pkg::WINDOW_RESET;
    logic                         btn_last_raw = 1'b0;
    logic                         btn_stable = 1'b0;
    logic [dbclk_pkg::TIME_W-1:0] btn_change_ms = '0;
    logic [dbclk_pkg::TIME_W-1:0] click_first_ms = '0;
    logic                         click_pending = 1'b0;
    logic                         sel_made = 1'b0;
    dbclk_pkg::t_mode             sel_mode = dbclk_pkg::MODE_NONE;
    logic                         exit_req = 1'b0;

    t_sel_result                  selector_outcomes[$];
    int                           mismatch_count = 0;
    int                           quiet_cycles = 0;
    int                           sender_idle_pct = 0;
    int                           ready_stall_pct = 0;

    debounced_single_double_click_selector_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_sel_result poll_selector(
            input logic [dbclk_pkg::TIME_W-1:0] now_ms,
            input logic raw, input logic active,
            input logic consume, input logic clear);
        t_sel_result                  res;
        logic                         press;
        logic [dbclk_pkg::TIME_W-1:0] elapsed;
        res = '0;
        press = 1'b0;
        if (consume) begin
            res.exit_taken = exit_req;
            exit_req = 1'b0;
        end
        if (clear) begin
            sel_mode = dbclk_pkg::MODE_NONE;
            sel_made = 1'b0;
            click_pending = 1'b0;
        end
        if (raw != btn_last_raw) begin
            btn_last_raw = raw;
            btn_change_ms = now_ms;
        end
        elapsed = now_ms - btn_change_ms;
        if (elapsed >= dbclk_pkg::TIME_W'(debounce_ms_reg) && raw != btn_stable) begin
            btn_stable = raw;
            press = raw;
        end
        if (active) begin
            if (press) begin
                exit_req = 1'b1;
                click_pending = 1'b0;
                sel_mode = dbclk_pkg::MODE_NONE;
                sel_made = 1'b0;
            end
        end else if (!sel_made) begin
            if (press) begin
                if (!click_pending) begin
                    click_first_ms = now_ms;
                    click_pending = 1'b1;
                end else begin
                    sel_mode = dbclk_pkg::MODE_DOUBLE;
                    sel_made = 1'b1;
                    click_pending = 1'b0;
                end
            end
            elapsed = now_ms - click_first_ms;
            if (click_pending && elapsed >= dbclk_pkg::TIME_W'(window_ms_reg)) begin
                sel_mode = dbclk_pkg::MODE_SINGLE;
                sel_made = 1'b1;
                click_pending = 1'b0;
            end
        end
        res.exit_pending = exit_req;
        res.has_sel = sel_made;
        res.mode = sel_mode;
        res.level = btn_stable;
        res.clicks = click_pending;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [1:0] got,
                               input logic [1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_sel_result want;
        logic        busy;
        busy = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                busy = 1'b1;
                case (i_cfg_index)
                    dbclk_pkg::CFG_DEBOUNCE: debounce_ms_reg = i_cfg_wdata;
                    dbclk_pkg::CFG_WINDOW: window_ms_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                busy = 1'b1;
                selector_outcomes.push_back(poll_selector(i_time_now, i_raw_pressed,
                    i_mode_active, i_consume_exit, i_clear_selection));
            end
            if (o_valid && i_ready) begin
                busy = 1'b1;
                if (selector_outcomes.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    want = selector_outcomes.pop_front();
                    check_field("exit_taken", o_exit_taken, want.exit_taken);
                    check_field("exit_pending", o_exit_pending, want.exit_pending);
                    check_field("has_selection", o_has_selection, want.has_sel);
                    check_field("chosen_mode", o_chosen_mode, want.mode);
                    check_field("debounced_level", o_debounced_level, want.level);
                    check_field("clicks_waiting", o_clicks_waiting, want.clicks);
                end
            end
        end
        quiet_cycles = busy ? 0 : quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(negedge i_clk) begin
        i_ready = ($urandom_range(0, 99) >= ready_stall_pct);
    end

    task automatic send_poll(input logic [dbclk_pkg::TIME_W-1:0] now_ms, input logic raw,
                             input logic active, input logic consume, input logic clear);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_time_now = now_ms;
        i_raw_pressed = raw;
        i_mode_active = active;
        i_consume_exit = consume;
        i_clear_selection = clear;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (selector_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_timing(input logic [dbclk_pkg::CFG_W-1:0] debounce_ms,
                                input logic [dbclk_pkg::CFG_W-1:0] window_ms);
        wait_results_drained();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = dbclk_pkg::CFG_DEBOUNCE;
        i_cfg_wdata = debounce_ms;
        @(negedge i_clk);
        i_cfg_index = dbclk_pkg::CFG_WINDOW;
        i_cfg_wdata = window_ms;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic test_click_selection();
        send_poll(100, 1, 0, 0, 0);
        send_poll(129, 1, 0, 0, 0);
        send_poll(130, 1, 0, 0, 0);
        send_poll(140, 0, 0, 0, 0);
        send_poll(170, 0, 0, 0, 0);
        send_poll(579, 0, 0, 0, 0);
        send_poll(580, 0, 0, 0, 0);
        send_poll(600, 0, 0, 0, 1);
        send_poll(700, 1, 0, 0, 0);
        send_poll(730, 1, 0, 0, 0);
        send_poll(740, 0, 0, 0, 0);
        send_poll(770, 0, 0, 0, 0);
        send_poll(800, 1, 0, 0, 0);
        send_poll(830, 1, 0, 0, 0);
    endtask

    task automatic test_exit_request();
        send_poll(860, 0, 0, 0, 0);
        send_poll(890, 0, 0, 0, 0);
        send_poll(900, 1, 0, 0, 0);
        send_poll(930, 1, 0, 0, 0);
        send_poll(940, 0, 1, 0, 0);
        send_poll(970, 0, 1, 0, 0);
        send_poll(980, 1, 1, 0, 0);
        send_poll(1010, 1, 1, 0, 0);
        send_poll(1020, 1, 0, 1, 1);
    endtask

    task automatic test_zero_times();
        write_timing(16'd0, 16'd0);
        send_poll(2000, 0, 0, 0, 0);
        send_poll(2000, 1, 0, 0, 0);
        send_poll(2001, 0, 0, 0, 1);
    endtask

    task automatic test_max_times_wrap();
        write_timing(16'hFFFF, 16'hFFFF);
        send_poll(32'hFFFF_FFF0, 1, 0, 0, 0);
        send_poll(32'h0000_FFEF, 1, 0, 0, 0);
        send_poll(32'h0001_FFED, 1, 0, 0, 0);
        send_poll(32'h0001_FFEE, 1, 0, 0, 0);
    endtask

    task automatic test_random_polls(input int count, input int debounce_ms,
                                     input int window_ms, input int idle_pct,
                                     input int stall_pct, input bit pause_midway);
        logic [dbclk_pkg::TIME_W-1:0] now_ms;
        logic                         btn_target;
        logic                         mode_running;
        logic                         raw;
        logic                         active;
        logic                         consume;
        logic                         clear;
        write_timing(debounce_ms[dbclk_pkg::CFG_W-1:0], window_ms[dbclk_pkg::CFG_W-1:0]);
        sender_idle_pct = idle_pct;
        ready_stall_pct = stall_pct;
        now_ms = ($urandom_range(0, 1) == 1) ? $urandom
                                             : 32'hFFFF_FFFF - $urandom_range(0, 1000);
        btn_target = 1'b0;
        mode_running = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (pause_midway && n == count / 2) begin
                wait_results_drained();
            end
            if ($urandom_range(0, 11) == 0) begin
                send_poll($urandom, $urandom_range(0, 1), $urandom_range(0, 1),
                          $urandom_range(0, 1), $urandom_range(0, 1));
            end else begin
                if ($urandom_range(0, 19) == 0) begin
                    now_ms += $urandom_range(0, debounce_ms + window_ms + 2);
                end else begin
                    now_ms += $urandom_range(0, debounce_ms / 4 + 1);
                end
                if ($urandom_range(0, 9) == 0) btn_target = ~btn_target;
                raw = ($urandom_range(0, 9) == 0) ? ~btn_target : btn_target;
                if (!mode_running && sel_made && $urandom_range(0, 3) == 0) begin
                    mode_running = 1'b1;
                end
                active = mode_running;
                consume = ($urandom_range(0, 19) == 0);
                clear = ($urandom_range(0, 29) == 0);
                if (mode_running && exit_req && $urandom_range(0, 1) == 1) begin
                    consume = 1'b1;
                    clear = 1'b1;
                    mode_running = 1'b0;
                end
                if (!mode_running && sel_made && $urandom_range(0, 9) == 0) clear = 1'b1;
                if ($urandom_range(0, 24) == 0) active = ~active;
                send_poll(now_ms, raw, active, consume, clear);
            end
        end
        sender_idle_pct = 0;
        ready_stall_pct = 0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_click_selection();
        test_exit_request();
        test_zero_times();
        test_max_times_wrap();
        test_random_polls(300, 4, 24, 0, 0, 1'b0);
        test_random_polls(300, 0, 0, 60, 0, 1'b0);
        test_random_polls(300, 65535, 65535, 0, 60, 1'b1);
        test_random_polls(300, $urandom_range(0, 40), $urandom_range(0, 300), 19, 19, 1'b0);
        test_random_polls(300, 30, 450, 0, 0, 1'b0);
        @(negedge i_clk);
        i_valid = 1'b0;
        for (int n = 0; n < 2000 && selector_outcomes.size() != 0; n++) @(posedge i_clk);
        if (selector_outcomes.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", selector_outcomes.size()));
        end
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/dbclk_pkg.sv
rtl/core/debounced_single_double_click_selector_unit.sv
rtl/core/dbclk_checker.sv
tb/sv/tb_top.sv
